// ----- rtl/nalsp_pkg.sv -----
// Shared types and constants of the Annex B NAL unit splitter.
`timescale 1ns / 1ps

package nalsp_pkg;

  // Most results that one input beat can give: four payload bytes and one descriptor.
  localparam int unsigned NSLOT = 5;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DESC    = 1'b1;

  // NAL unit types of interest and the type field mask.
  localparam logic [7:0] TYPE_MASK = 8'h1f;
  localparam logic [4:0] TYPE_IDR  = 5'd5;
  localparam logic [4:0] TYPE_SPS  = 5'd7;
  localparam logic [4:0] TYPE_PPS  = 5'd8;

  // Byte that closes a start code, and the most zeros held back.
  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [1:0] HOLD_MAX   = 2'd3;

  // One result without its size field, which follows the size parameter.
  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    logic [4:0] utype;
    logic       key;
    logic       first;
  } res_t;

endpackage

// ----- rtl/nalsp_parser.sv -----
// Start code detection, unit state and result generation for one input beat.
`timescale 1ns / 1ps

module nalsp_parser #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         step_i,
  input  logic [7:0]                                   byte_i,
  input  logic                                         eob_i,
  input  logic                                         pass_ps_i,
  output logic [2:0]                                   cnt_o,
  output nalsp_pkg::res_t [nalsp_pkg::NSLOT-1:0]       res_o,
  output logic [nalsp_pkg::NSLOT-1:0][SIZE_BITS-1:0]   size_o
);
  import nalsp_pkg::*;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  // Unit state. Held bytes are always zeros, so only their count is kept.
  logic [1:0]           hold_q, hold_d;
  logic                 inside_q, inside_d;
  logic                 await_q, await_d;
  logic [4:0]           type_q, type_d;
  logic [SIZE_BITS-1:0] count_q, count_d;

  logic                 is_zero, is_start, has_b, full;
  logic [1:0]           hold_after;
  logic                 ins, aw, d1, d2, suppress;
  logic [4:0]           ty, new_type;
  logic [SIZE_BITS-1:0] cnt, cnt_new;
  logic [SIZE_BITS:0]   cnt_sum;
  logic [2:0]           nz, np, npe, off, pos;
  logic [7:0]           first_byte;

  // Classify the beat and work out how many bytes it passes into the unit.
  always_comb begin
    is_zero    = (byte_i == 8'h00);
    is_start   = (byte_i == START_BYTE) && (hold_q >= 2'd2);
    has_b      = !is_zero && !is_start;
    full       = (hold_q == HOLD_MAX);
    hold_after = full ? HOLD_MAX : hold_q + 2'd1;

    if (is_zero) begin
      nz = {2'b00, full} + (eob_i ? {1'b0, hold_after} : 3'd0);
    end else if (is_start) begin
      nz = 3'd0;
    end else begin
      nz = {1'b0, hold_q};
    end
    np = nz + {2'b00, has_b};

    // A start code opens a fresh unit before anything else of this beat.
    d1  = is_start && inside_q;
    ins = is_start ? 1'b1 : inside_q;
    aw  = is_start ? 1'b1 : await_q;
    ty  = is_start ? 5'd0 : type_q;
    cnt = is_start ? '0 : count_q;

    // The first passed byte of a unit sets its type.
    first_byte = (nz != 3'd0) ? 8'h00 : byte_i;
    if (ins && aw && (np != 3'd0)) begin
      new_type = 5'(first_byte & TYPE_MASK);
    end else begin
      new_type = ty;
    end

    // Saturating byte count of the open unit.
    cnt_sum = {1'b0, cnt} + (SIZE_BITS + 1)'(np);
    if (!ins) begin
      cnt_new = cnt;
    end else if (cnt_sum[SIZE_BITS]) begin
      cnt_new = SIZE_MAX;
    end else begin
      cnt_new = cnt_sum[SIZE_BITS-1:0];
    end

    suppress = !pass_ps_i && ((new_type == TYPE_SPS) || (new_type == TYPE_PPS));
    npe      = (ins && !suppress) ? np : 3'd0;
    d2       = eob_i && ins;
    off      = {2'b00, d1};
    cnt_o    = off + npe + {2'b00, d2};
  end

  // Lay the results out in order: closing descriptor, payload bytes, final descriptor.
  always_comb begin
    for (int k = 0; k < NSLOT; k++) begin
      pos       = 3'(k) - off;
      res_o[k]  = '0;
      size_o[k] = '0;
      if (d1 && (k == 0)) begin
        res_o[k].kind  = KIND_DESC;
        res_o[k].utype = type_q;
        res_o[k].key   = (type_q == TYPE_IDR);
        size_o[k]      = count_q;
      end else if (pos < npe) begin
        res_o[k].kind  = KIND_PAYLOAD;
        res_o[k].pbyte = (has_b && (pos == np - 3'd1)) ? byte_i : 8'h00;
        res_o[k].utype = new_type;
        res_o[k].key   = (new_type == TYPE_IDR);
        res_o[k].first = aw && (pos == 3'd0);
      end else if (d2 && (pos == npe)) begin
        res_o[k].kind  = KIND_DESC;
        res_o[k].utype = new_type;
        res_o[k].key   = (new_type == TYPE_IDR);
        size_o[k]      = cnt_new;
      end
    end
  end

  // Next state; the end of the buffer closes the unit and restarts the search.
  always_comb begin
    if (eob_i) begin
      hold_d   = 2'd0;
      inside_d = 1'b0;
      await_d  = 1'b0;
      type_d   = 5'd0;
      count_d  = '0;
    end else begin
      hold_d   = is_zero ? hold_after : 2'd0;
      inside_d = ins;
      await_d  = ins ? (aw && (np == 3'd0)) : aw;
      type_d   = new_type;
      count_d  = cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= 2'd0;
      inside_q <= 1'b0;
      await_q  <= 1'b0;
      type_q   <= 5'd0;
      count_q  <= '0;
    end else if (step_i) begin
      hold_q   <= hold_d;
      inside_q <= inside_d;
      await_q  <= await_d;
      type_q   <= type_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/nalsp_burst_buf.sv -----
// Result register handing out one beat's results one a cycle while output is ready.
`timescale 1ns / 1ps

module nalsp_burst_buf #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         load_i,
  input  logic [2:0]                                   cnt_i,
  input  nalsp_pkg::res_t [nalsp_pkg::NSLOT-1:0]       res_i,
  input  logic [nalsp_pkg::NSLOT-1:0][SIZE_BITS-1:0]   size_i,
  input  logic                                         pop_ready_i,
  output logic                                         ready_o,
  output logic                                         valid_o,
  output nalsp_pkg::res_t                              res_o,
  output logic [SIZE_BITS-1:0]                         size_o,
  output logic                                         last_o
);
  import nalsp_pkg::*;

  res_t [NSLOT-1:0]                slot_q;
  logic [NSLOT-1:0][SIZE_BITS-1:0] size_q;
  logic [2:0]                      count_q;
  logic                            pop;

  // The head slot drives the output; the last slot of a burst carries the run end.
  assign valid_o = (count_q != 3'd0);
  assign pop     = valid_o && pop_ready_i;
  assign ready_o = (count_q == 3'd0) || ((count_q == 3'd1) && pop_ready_i);
  assign res_o   = slot_q[0];
  assign size_o  = size_q[0];
  assign last_o  = (count_q == 3'd1);

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else if (load_i) begin
      count_q <= cnt_i;
    end else if (pop) begin
      count_q <= count_q - 3'd1;
    end
  end

  // Slots load as a whole and shift towards the head as beats leave.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= res_i;
      size_q <= size_i;
    end else if (pop) begin
      for (int k = 0; k < NSLOT - 1; k++) begin
        slot_q[k] <= slot_q[k+1];
        size_q[k] <= size_q[k+1];
      end
    end
  end

endmodule

// ----- rtl/annexb_nal_unit_splitter.sv -----
// Top level of the Annex B NAL unit splitter.
`timescale 1ns / 1ps

// Takes an H.264 Annex B stream one byte per beat (tlast marks the last byte of a
// buffer) and gives payload bytes with start codes removed, each unit closed by a
// descriptor beat (tuser high) carrying type, saturating size and keyframe mark.
// A byte passes through an input register, the parser and a result register, and
// its results are offered from the result register. The block takes one byte per
// clock while each byte gives at most one result and the output is ready; a byte
// that gives n results (up to five, when held zeros are released, at a start code
// or at a buffer end) keeps the result register until the single result port has
// drained them all, and the next byte waits in the input register until then. tlast
// on the output marks the last result caused by one input byte. Payload of SPS and
// PPS units is dropped unless the configuration bit is set; their descriptors are
// always given.

module annexb_nal_unit_splitter #(
  parameter  int unsigned SIZE_BITS = 24,
  localparam int unsigned TDATA_W   = ((15 + SIZE_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: bit 0 is pass_parameter_sets.
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // stream_byte
  input  logic               s_axis_tlast,   // end_of_buffer
  // Output stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // payload_byte, unit_type, unit_size,
                                             // is_keyframe, is_first, zero fill
  output logic               m_axis_tlast,   // last_of_run
  output logic               m_axis_tuser    // item_kind
);
  import nalsp_pkg::*;

  logic                            pass_ps_q;
  logic                            in_vld_q;
  logic [7:0]                      in_byte_q;
  logic                            in_eob_q;
  logic                            buf_ready, take;
  logic [2:0]                      burst_cnt;
  res_t [NSLOT-1:0]                burst_res;
  logic [NSLOT-1:0][SIZE_BITS-1:0] burst_size;
  res_t                            head_res;
  logic [SIZE_BITS-1:0]            head_size;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_ps_q <= 1'b0;
    end else if (cfg_we_i) begin
      pass_ps_q <= cfg_wdata_i;
    end
  end

  // Input register; it empties when the result register can take the beat's results.
  assign take          = in_vld_q && buf_ready;
  assign s_axis_tready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eob_q  <= s_axis_tlast;
    end
  end

  nalsp_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (take),
    .byte_i    (in_byte_q),
    .eob_i     (in_eob_q),
    .pass_ps_i (pass_ps_q),
    .cnt_o     (burst_cnt),
    .res_o     (burst_res),
    .size_o    (burst_size)
  );

  nalsp_burst_buf #(
    .SIZE_BITS (SIZE_BITS)
  ) u_burst_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .cnt_i       (burst_cnt),
    .res_i       (burst_res),
    .size_i      (burst_size),
    .pop_ready_i (m_axis_tready),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .res_o       (head_res),
    .size_o      (head_size),
    .last_o      (m_axis_tlast)
  );

  // Output beat packing, lowest field first.
  assign m_axis_tuser = head_res.kind;
  assign m_axis_tdata = TDATA_W'({head_res.first, head_res.key, head_size,
                                  head_res.utype, head_res.pbyte});

endmodule
